// File: sv/sbs_pkg.sv
// Shared types and constants for the sorted table search block.
// Used by sbs_step, sorted_table_binary_search and sbs_checker; no dependencies.
package sbs_pkg;

   // Fixed field widths of the stream payloads
   localparam int SLOT_W  = 10;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 10;
   localparam int BOUND_W = 10;

   // Function codes carried in req_tuser
   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_EXACT = 2'd1;
   localparam logic [1:0] FUNC_LOWER = 2'd2;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PROBE = 4'b0010,
      ST_CMP   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // Outcome of one probe step
   typedef struct packed {
      logic hit;   // exact match at the probed index
      logic more;  // range still non-empty, probe again
   } step_flags_type;

endpackage

// File: sv/sbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/sbs_step.sv
// Shared compare and bound-update unit: one bisection step per use.
// Depends on sbs_pkg.
module sbs_step #(
   parameter int ELEMENT_BITS = 32,
   parameter int PTR_W        = 12
) (
   input  logic                    exact,
   input  logic signed [PTR_W-1:0] low,
   input  logic signed [PTR_W-1:0] high,
   input  logic signed [PTR_W-1:0] mid,
   input  logic [ELEMENT_BITS-1:0] elem,
   input  logic [sbs_pkg::VALUE_W-1:0] key,
   output logic signed [PTR_W-1:0] low_in,
   output logic signed [PTR_W-1:0] high_in,
   output sbs_pkg::step_flags_type flags
);

   localparam int CMP_W = (ELEMENT_BITS > sbs_pkg::VALUE_W) ? ELEMENT_BITS
                                                            : sbs_pkg::VALUE_W;

   logic signed [CMP_W-1:0] elem_ext;
   logic signed [CMP_W-1:0] key_ext;
   logic                    key_lt;
   logic                    key_eq;
   logic                    go_left;

   // signed compare at the common width
   assign elem_ext = CMP_W'(signed'(elem));
   assign key_ext  = CMP_W'(signed'(key));
   assign key_lt   = key_ext < elem_ext;
   assign key_eq   = key_ext == elem_ext;

   // lower bound moves left on equal as well
   assign go_left = exact ? key_lt : (key_lt | key_eq);

   always_comb begin
      low_in  = low;
      high_in = high;
      if (go_left) begin
         high_in = mid - PTR_W'(1);
      end else begin
         low_in = mid + PTR_W'(1);
      end
      flags.hit  = exact & key_eq;
      flags.more = !(exact & key_eq) && (low_in <= high_in);
   end

endmodule

// File: sv/sorted_table_binary_search.sv
// Top level of the sorted table search block: sequencer, table RAM, result register.
// Depends on sbs_pkg, sbs_ram and sbs_step.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tuser: func; tdata: slot, value
//  rsp     | out | rsp_tvalid/tready   | tuser: found; tdata: position
//  csr     | in  | csr_valid/ready     | csr_data: last_index
//
// A load or an unused function code leaves the sequencer idle; the next item is taken at once.
// A search makes one probe per pass through ST_PROBE (RAM read) and ST_CMP (compare and
// bound update), at most log2(TABLE_DEPTH)+1 probes, then posts the result from ST_DONE,
// so a new search is taken only after the last one's result has been posted.
// req_tready is low while a search runs and while its result waits on a full rsp register.
// Synchronous active-high reset clears control state and last_index; the table is not cleared.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int ELEMENT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic [47:0] req_tdata,   // [9:0] slot, [41:10] value, [47:42] zero
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,   // [0] found
   output logic [15:0] rsp_tdata,   // [9:0] position, [15:10] zero
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int PTR_W  = IDX_W + 2;
   localparam int WIDE_W = 17;

   sbs_pkg::state_type state_ff, state_in;

   logic [sbs_pkg::BOUND_W-1:0] last_index_ff;
   logic signed [PTR_W-1:0]     low_ff, low_in;
   logic signed [PTR_W-1:0]     high_ff, high_in;
   logic signed [PTR_W-1:0]     bound_ff, bound_in;
   logic signed [PTR_W-1:0]     mid_ff, mid_in;
   logic [sbs_pkg::VALUE_W-1:0] key_ff, key_in;
   logic                        exact_ff, exact_in;
   logic                        res_found_ff, res_found_in;
   logic [sbs_pkg::POS_W-1:0]   res_pos_ff, res_pos_in;
   logic                        rsp_valid_ff;
   logic                        rsp_found_ff;
   logic [sbs_pkg::POS_W-1:0]   rsp_pos_ff;

   logic [1:0]                  req_func;
   logic [sbs_pkg::SLOT_W-1:0]  req_slot;
   logic [sbs_pkg::VALUE_W-1:0] req_value;
   logic                        req_fire;
   logic                        out_free;
   logic                        post_result;
   logic [WIDE_W-1:0]           slot_wide;
   logic [WIDE_W-1:0]           last_wide;
   logic signed [PTR_W-1:0]     high_start;
   logic signed [PTR_W-1:0]     mid_sum;

   logic                        ram_we;
   logic [IDX_W-1:0]            ram_waddr;
   logic [ELEMENT_BITS-1:0]     ram_wdata;
   logic [IDX_W-1:0]            ram_raddr;
   logic [ELEMENT_BITS-1:0]     ram_rdata;

   logic signed [PTR_W-1:0]     step_low;
   logic signed [PTR_W-1:0]     step_high;
   sbs_pkg::step_flags_type     step_flags;
   logic [WIDE_W-1:0]           low_wide;
   logic [WIDE_W-1:0]           mid_wide;

   // payload unpacking
   assign req_func  = req_tuser;
   assign req_slot  = req_tdata[9:0];
   assign req_value = req_tdata[41:10];

   assign req_tready = (state_ff == sbs_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff | rsp_tready;
   assign post_result = (state_ff == sbs_pkg::ST_DONE) & out_free;

   // configuration register, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         last_index_ff <= '0;
      end else if (csr_valid) begin
         last_index_ff <= csr_data;
      end
   end

   // search bound, saturated to the table
   assign last_wide  = WIDE_W'(last_index_ff);
   assign high_start = (last_wide >= WIDE_W'(TABLE_DEPTH - 1)) ? PTR_W'(TABLE_DEPTH - 1)
                                                               : PTR_W'(last_wide);

   // load path
   assign slot_wide = WIDE_W'(req_slot);
   assign ram_we    = req_fire && (req_func == sbs_pkg::FUNC_LOAD)
                      && (slot_wide < WIDE_W'(TABLE_DEPTH));
   assign ram_waddr = slot_wide[IDX_W-1:0];
   assign ram_wdata = ELEMENT_BITS'(64'(signed'(req_value)));

   // midpoint of the current range, feeds the RAM read address
   assign mid_sum   = low_ff + high_ff;
   assign ram_raddr = mid_in[IDX_W-1:0];

   sbs_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sbs_step #(
      .ELEMENT_BITS (ELEMENT_BITS),
      .PTR_W        (PTR_W)
   ) u_step (
      .exact   (exact_ff),
      .low     (low_ff),
      .high    (high_ff),
      .mid     (mid_ff),
      .elem    (ram_rdata),
      .key     (key_ff),
      .low_in  (step_low),
      .high_in (step_high),
      .flags   (step_flags)
   );

   assign low_wide = WIDE_W'(unsigned'(step_low));
   assign mid_wide = WIDE_W'(unsigned'(mid_ff));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      bound_in     = bound_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      exact_in     = exact_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      case (state_ff)
         sbs_pkg::ST_IDLE: begin
            if (req_fire && (req_func == sbs_pkg::FUNC_EXACT
                             || req_func == sbs_pkg::FUNC_LOWER)) begin
               low_in   = '0;
               high_in  = high_start;
               bound_in = high_start;
               key_in   = req_value;
               exact_in = (req_func == sbs_pkg::FUNC_EXACT);
               state_in = sbs_pkg::ST_PROBE;
            end
         end
         sbs_pkg::ST_PROBE: begin
            mid_in   = mid_sum >>> 1;
            state_in = sbs_pkg::ST_CMP;
         end
         sbs_pkg::ST_CMP: begin
            low_in  = step_low;
            high_in = step_high;
            if (step_flags.more) begin
               state_in = sbs_pkg::ST_PROBE;
            end else begin
               state_in = sbs_pkg::ST_DONE;
               if (exact_ff) begin
                  res_found_in = step_flags.hit;
                  res_pos_in   = step_flags.hit ? mid_wide[sbs_pkg::POS_W-1:0] : '0;
               end else begin
                  res_found_in = (step_low <= bound_ff);
                  res_pos_in   = (step_low <= bound_ff) ? low_wide[sbs_pkg::POS_W-1:0]
                                                        : '0;
               end
            end
         end
         sbs_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = sbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      low_ff       <= low_in;
      high_ff      <= high_in;
      bound_ff     <= bound_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      exact_ff     <= exact_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
   end

   // response register, decouples the sequencer from rsp stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (post_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (post_result) begin
         rsp_found_ff <= res_found_ff;
         rsp_pos_ff   <= res_pos_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {6'b0, rsp_pos_ff};

endmodule

// File: sv/sbs_checker.sv
// Port-level checks for sorted_table_binary_search, attached with bind.
// Depends on sbs_pkg and the top level's ports.
module sbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [0:0]  rsp_tuser,
   input logic [15:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [9:0]  csr_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // not found reports position zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[9:0] == 10'd0)
      else $error("not-found response with nonzero position");

   // a search transfer closes the request side
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready
      && (req_tuser == sbs_pkg::FUNC_EXACT || req_tuser == sbs_pkg::FUNC_LOWER)
      |=> !req_tready)
      else $error("request accepted during a search");

   // a load or unused code leaves the request side open
   a_load_open: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready
      && req_tuser != sbs_pkg::FUNC_EXACT && req_tuser != sbs_pkg::FUNC_LOWER
      |=> req_tready)
      else $error("request side closed after a load");

   // a new response only ends a search
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response without a running search");

endmodule

bind sorted_table_binary_search sbs_checker u_sbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_data   (csr_data)
);
